FILE: hdl/bcc_pkg.sv
package bcc_pkg;

    localparam int CfgWidth  = 16;
    localparam int CfgAddrW  = 3;
    localparam int TimeWidth = 32;

    typedef logic [1:0] evt_t;

    localparam evt_t EV_NONE   = 2'd0;
    localparam evt_t EV_SHORT  = 2'd1;
    localparam evt_t EV_LONG   = 2'd2;
    localparam evt_t EV_DOUBLE = 2'd3;

    localparam logic [CfgAddrW-1:0] REG_HOLD_LONG    = 3'd0;
    localparam logic [CfgAddrW-1:0] REG_RELEASE_LONG = 3'd1;
    localparam logic [CfgAddrW-1:0] REG_SHORT_MIN    = 3'd2;
    localparam logic [CfgAddrW-1:0] REG_DOUBLE_WIN   = 3'd3;

    localparam logic [CfgWidth-1:0] HOLD_LONG_RST    = 16'd1200;
    localparam logic [CfgWidth-1:0] RELEASE_LONG_RST = 16'd800;
    localparam logic [CfgWidth-1:0] SHORT_MIN_RST    = 16'd500;
    localparam logic [CfgWidth-1:0] DOUBLE_WIN_RST   = 16'd300;

    typedef struct packed {
        logic [CfgWidth-1:0] hold_long_ms;
        logic [CfgWidth-1:0] release_long_ms;
        logic [CfgWidth-1:0] short_min_ms;
        logic [CfgWidth-1:0] double_window_ms;
    } cfg_t;

endpackage

FILE: hdl/bcc_cfg.sv
module bcc_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bcc_pkg::CfgAddrW-1:0]    cfg_addr,
    input  logic [bcc_pkg::CfgWidth-1:0]    cfg_data,
    output bcc_pkg::cfg_t                   cfg
);
    import bcc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_HOLD_LONG:    cfg_next.hold_long_ms     = cfg_data;
                REG_RELEASE_LONG: cfg_next.release_long_ms  = cfg_data;
                REG_SHORT_MIN:    cfg_next.short_min_ms     = cfg_data;
                REG_DOUBLE_WIN:   cfg_next.double_window_ms = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_long_ms     <= HOLD_LONG_RST;
            cfg_reg.release_long_ms  <= RELEASE_LONG_RST;
            cfg_reg.short_min_ms     <= SHORT_MIN_RST;
            cfg_reg.double_window_ms <= DOUBLE_WIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/bcc_core.sv
module bcc_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic                            pressed,
    input  logic [bcc_pkg::TimeWidth-1:0]   now_ms,
    input  bcc_pkg::cfg_t                   cfg,
    output bcc_pkg::evt_t                   evt
);
    import bcc_pkg::*;

    logic                 is_pressing_reg, is_pressing_next;
    logic [TimeWidth-1:0] press_start_reg, press_start_next;
    logic                 click_armed_reg, click_armed_next;
    logic [TimeWidth-1:0] first_click_reg, first_click_next;

    logic [TimeWidth-1:0] held;
    logic [TimeWidth-1:0] since_click;
    logic [TimeWidth-1:0] hold_lim, rel_lim, short_lim, win_lim;

    assign hold_lim  = {{(TimeWidth-CfgWidth){1'b0}}, cfg.hold_long_ms};
    assign rel_lim   = {{(TimeWidth-CfgWidth){1'b0}}, cfg.release_long_ms};
    assign short_lim = {{(TimeWidth-CfgWidth){1'b0}}, cfg.short_min_ms};
    assign win_lim   = {{(TimeWidth-CfgWidth){1'b0}}, cfg.double_window_ms};

    // A press that starts on this sample has a held time of zero.
    assign held        = is_pressing_reg ? (now_ms - press_start_reg) : '0;
    assign since_click = now_ms - first_click_reg;

    always_comb
    begin
        is_pressing_next = is_pressing_reg;
        press_start_next = press_start_reg;
        click_armed_next = click_armed_reg;
        first_click_next = first_click_reg;
        evt              = EV_NONE;
        if (pressed)
        begin
            is_pressing_next = 1'b1;
            if (!is_pressing_reg)
            begin
                press_start_next = now_ms;
            end
            if (held > hold_lim)
            begin
                click_armed_next = 1'b0;
                evt              = EV_LONG;
            end
        end
        else if (is_pressing_reg)
        begin
            is_pressing_next = 1'b0;
            if (held > rel_lim)
            begin
                click_armed_next = 1'b0;
                evt              = EV_LONG;
            end
            else if (held > short_lim)
            begin
                click_armed_next = 1'b0;
                evt              = EV_SHORT;
            end
            else if (click_armed_reg)
            begin
                if (since_click < win_lim)
                begin
                    click_armed_next = 1'b0;
                    evt              = EV_DOUBLE;
                end
            end
            else
            begin
                first_click_next = now_ms;
                click_armed_next = 1'b1;
            end
        end
        else if (click_armed_reg && (since_click > win_lim))
        begin
            click_armed_next = 1'b0;
            evt              = EV_SHORT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_pressing_reg <= 1'b0;
            press_start_reg <= '0;
            click_armed_reg <= 1'b0;
            first_click_reg <= '0;
        end
        else if (advance)
        begin
            is_pressing_reg <= is_pressing_next;
            press_start_reg <= press_start_next;
            click_armed_reg <= click_armed_next;
            first_click_reg <= first_click_next;
        end
    end

endmodule

FILE: hdl/button_click_classifier.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------
// in       | in_valid / in_ready  | pressed, now_ms
// out      | out_valid / out_ready| event_res
// cfg      | cfg_we               | cfg_addr, cfg_data
//
// Each beat is registered in the input register, and its result is offered from the
// result register.
// One beat is accepted per cycle while the output side keeps taking results.
// A stalled output holds its result and the input register holds the next beat.
// Reset restores the default thresholds and clears the press and click state.
module button_click_classifier (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            pressed,
    input  logic [bcc_pkg::TimeWidth-1:0]   now_ms,
    output logic                            out_valid,
    input  logic                            out_ready,
    output bcc_pkg::evt_t                   event_res,
    input  logic                            cfg_we,
    input  logic [bcc_pkg::CfgAddrW-1:0]    cfg_addr,
    input  logic [bcc_pkg::CfgWidth-1:0]    cfg_data
);
    import bcc_pkg::*;

    cfg_t cfg;

    logic                 s1_valid_reg, s1_valid_next;
    logic                 s1_pressed_reg;
    logic [TimeWidth-1:0] s1_now_reg;
    logic                 s2_valid_reg, s2_valid_next;
    evt_t                 s2_evt_reg;
    evt_t                 evt;
    logic                 advance;
    logic                 take_in;

    assign advance  = s1_valid_reg && (!s2_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign take_in  = in_valid && in_ready;

    assign s1_valid_next = take_in || (s1_valid_reg && !advance);
    assign s2_valid_next = advance || (s2_valid_reg && !out_ready);

    bcc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    bcc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .pressed (s1_pressed_reg),
        .now_ms  (s1_now_reg),
        .cfg     (cfg),
        .evt     (evt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_pressed_reg <= pressed;
            s1_now_reg     <= now_ms;
        end
        if (advance)
        begin
            s2_evt_reg <= evt;
        end
    end

    assign out_valid = s2_valid_reg;
    assign event_res = s2_evt_reg;

endmodule

FILE: tb/button_click_classifier_tb.sv
module button_click_classifier_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bcc_pkg::*;

    localparam logic [CfgAddrW-1:0] REG_SPARE_LO = 3'd4;
    localparam logic [CfgAddrW-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic                 down;
        logic [TimeWidth-1:0] stamp;
    } sample_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic                 pressed   = 1'b0;
    logic [TimeWidth-1:0] now_ms    = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    evt_t                 event_res;
    logic                 cfg_we    = 1'b0;
    logic [CfgAddrW-1:0]  cfg_addr  = '0;
    logic [CfgWidth-1:0]  cfg_data  = '0;

    button_click_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pressed   (pressed),
        .now_ms    (now_ms),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .event_res (event_res),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    // Thresholds and press/click state as the block should hold them.
    logic [CfgWidth-1:0]  thr_hold      = HOLD_LONG_RST;
    logic [CfgWidth-1:0]  thr_release   = RELEASE_LONG_RST;
    logic [CfgWidth-1:0]  thr_short     = SHORT_MIN_RST;
    logic [CfgWidth-1:0]  thr_window    = DOUBLE_WIN_RST;
    logic                 btn_down      = 1'b0;
    logic [TimeWidth-1:0] down_since    = '0;
    logic                 click_pending = 1'b0;
    logic [TimeWidth-1:0] click_at      = '0;

    sample_t              samples_q[$];
    evt_t                 expected_events[$];
    int                   queued        = 0;
    int                   results_seen  = 0;
    int                   mismatches    = 0;
    int                   send_gap      = 0;
    int                   take_gap      = 0;
    int                   gap_odds      = 10;
    logic                 calm          = 1'b0;
    logic [TimeWidth-1:0] clock_ms      = '0;
    sample_t              next_sample;
    evt_t                 got_event;

    function automatic evt_t classify_sample(input logic down, input logic [TimeWidth-1:0] t);
        logic [TimeWidth-1:0] held;
        if (down) begin
            if (!btn_down) begin
                btn_down   = 1'b1;
                down_since = t;
            end
            held = t - down_since;
            if (held > thr_hold) begin
                click_pending = 1'b0;
                return EV_LONG;
            end
            return EV_NONE;
        end
        if (btn_down) begin
            held     = t - down_since;
            btn_down = 1'b0;
            if (held > thr_release) begin
                click_pending = 1'b0;
                return EV_LONG;
            end
            if (held > thr_short) begin
                click_pending = 1'b0;
                return EV_SHORT;
            end
            if (click_pending) begin
                if (TimeWidth'(t - click_at) < thr_window) begin
                    click_pending = 1'b0;
                    return EV_DOUBLE;
                end
            end else begin
                click_at      = t;
                click_pending = 1'b1;
            end
            return EV_NONE;
        end
        if (click_pending && TimeWidth'(t - click_at) > thr_window) begin
            click_pending = 1'b0;
            return EV_SHORT;
        end
        return EV_NONE;
    endfunction

    task automatic note_mismatch(input evt_t want, input evt_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("event mismatch on result %0d: expected %0d, got %0d",
                     results_seen, want, got);
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            pressed  <= 1'b0;
            now_ms   <= '0;
            send_gap <= 0;
        end else begin
            if (in_valid && in_ready)
                expected_events.push_back(classify_sample(pressed, now_ms));
            if (!in_valid || in_ready) begin
                if (!calm && send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, gap_odds) == 0) begin
                    send_gap <= $urandom_range(1, 15);
                    in_valid <= 1'b0;
                end else if (samples_q.size() != 0) begin
                    next_sample = samples_q.pop_front();
                    in_valid <= 1'b1;
                    pressed  <= next_sample.down;
                    now_ms   <= next_sample.stamp;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            take_gap  <= 0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (expected_events.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %0d with nothing pending", event_res);
                end else begin
                    got_event = expected_events.pop_front();
                    if (event_res !== got_event)
                        note_mismatch(got_event, event_res);
                end
            end
            if (!calm && take_gap > 0) begin
                take_gap  <= take_gap - 1;
                out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, gap_odds) == 0) begin
                take_gap  <= $urandom_range(1, 15);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic push_sample(input logic down, input logic [TimeWidth-1:0] t);
        samples_q.push_back('{down: down, stamp: t});
        queued++;
    endtask

    task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgWidth-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_HOLD_LONG:    thr_hold    = val;
            REG_RELEASE_LONG: thr_release = val;
            REG_SHORT_MIN:    thr_short   = val;
            REG_DOUBLE_WIN:   thr_window  = val;
            default: ;
        endcase
    endtask

    task automatic set_thresholds(input logic [CfgWidth-1:0] hold, input logic [CfgWidth-1:0] rel,
                                  input logic [CfgWidth-1:0] short_min,
                                  input logic [CfgWidth-1:0] window);
        write_reg(REG_HOLD_LONG, hold);
        write_reg(REG_RELEASE_LONG, rel);
        write_reg(REG_SHORT_MIN, short_min);
        write_reg(REG_DOUBLE_WIN, window);
    endtask

    // Waits until every queued beat has produced its result.
    task automatic settle();
        while (results_seen < queued)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Durations cluster around the thresholds so every compare is hit at its edge.
    function automatic logic [TimeWidth-1:0] pick_span();
        logic [TimeWidth-1:0] mark;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                case ($urandom_range(0, 3))
                    0:       mark = thr_hold;
                    1:       mark = thr_release;
                    2:       mark = thr_short;
                    default: mark = thr_window;
                endcase
                return mark + $urandom_range(0, 4) - 2;
            end
            6, 7:    return $urandom_range(0, 50);
            8:       return $urandom;
            default: return '0;
        endcase
    endfunction

    task automatic click_burst();
        logic [TimeWidth-1:0] t0;
        int                   n;
        t0 = clock_ms + (($urandom_range(0, 2) == 0) ? pick_span() : $urandom_range(0, 8));
        push_sample(1'b1, t0);
        n = $urandom_range(0, 2);
        repeat (n) push_sample(1'b1, t0 + pick_span());
        clock_ms = t0 + pick_span();
        push_sample(1'b0, clock_ms);
        n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0;
        repeat (n) begin
            clock_ms = clock_ms + pick_span();
            push_sample(1'b0, clock_ms);
        end
    endtask

    task automatic random_traffic(input int count);
        int goal;
        goal = queued + count;
        clock_ms = $urandom;
        while (queued < goal) begin
            if ($urandom_range(0, 9) == 0)
                push_sample(1'($urandom_range(0, 1)), $urandom);
            else
                click_burst();
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Hold threshold edge, then long release.
        push_sample(1'b0, 32'd0);
        push_sample(1'b1, 32'd0);
        push_sample(1'b1, 32'd1200);
        push_sample(1'b1, 32'd1201);
        push_sample(1'b0, 32'd1202);
        // Release exactly at the long limit gives a short press.
        push_sample(1'b1, 32'd3000);
        push_sample(1'b0, 32'd3800);
        // Quick click, idle at the exact window edge, then a late second click.
        push_sample(1'b1, 32'd4000);
        push_sample(1'b0, 32'd4500);
        push_sample(1'b0, 32'd4800);
        push_sample(1'b1, 32'd4800);
        push_sample(1'b0, 32'd4800);
        push_sample(1'b0, 32'd4801);
        // Double click across the timestamp wrap.
        push_sample(1'b1, 32'hFFFF_FFF0);
        push_sample(1'b0, 32'h0000_0010);
        push_sample(1'b1, 32'h0000_0020);
        push_sample(1'b0, 32'h0000_0040);
        // An armed click is not timed out while the button is held.
        push_sample(1'b1, 32'h0000_1000);
        push_sample(1'b0, 32'h0000_1010);
        push_sample(1'b1, 32'h0000_1400);
        push_sample(1'b0, 32'h0000_1401);
        push_sample(1'b0, 32'h0000_1402);
        // Release stamped before the press.
        push_sample(1'b1, 32'h0000_2000);
        push_sample(1'b0, 32'h0000_1FFF);
        push_sample(1'b0, 32'hFFFF_FFFF);
        settle();

        // Writes to indexes past the last register must not disturb the thresholds.
        write_reg(REG_SPARE_HI, '1);
        write_reg(REG_SPARE_LO, '0);
        gap_odds = $urandom_range(3, 40);
        random_traffic(100);
        settle();

        set_thresholds(16'd40, 16'd30, 16'd20, 16'd25);
        gap_odds = $urandom_range(3, 40);
        random_traffic(400);
        settle();

        set_thresholds('0, '0, '0, '0);
        gap_odds = $urandom_range(3, 40);
        random_traffic(250);
        settle();

        set_thresholds('1, '1, '1, '1);
        gap_odds = $urandom_range(3, 40);
        random_traffic(250);
        settle();

        set_thresholds(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        gap_odds = $urandom_range(3, 40);
        random_traffic(500);
        settle();

        set_thresholds(16'($urandom_range(0, 100)), 16'($urandom_range(0, 100)),
                       16'($urandom_range(0, 100)), 16'($urandom_range(0, 100)));
        calm = 1'b1;
        random_traffic(500);
        settle();

        if (expected_events.size() != 0) begin
            mismatches += expected_events.size();
            $display("%0d expected results never arrived", expected_events.size());
        end
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/bcc_pkg.sv
hdl/bcc_cfg.sv
hdl/bcc_core.sv
hdl/button_click_classifier.sv
tb/button_click_classifier_tb.sv
